/* rtl/mcp_pkg.sv */
// motor command parser package: character codes, status and direction codes,
// buffer types and the control struct passed from the matcher to the top level
// no dependencies
`default_nettype none

package mcp_pkg;

  localparam int BUF_DEPTH = 10;
  localparam int CNT_W     = $clog2(BUF_DEPTH + 1);
  localparam int DUTY_W    = 10;

  localparam logic [7:0] CHAR_R      = 8'h52;
  localparam logic [7:0] CHAR_L      = 8'h4c;
  localparam logic [7:0] CHAR_MINUS  = 8'h2d;
  localparam logic [7:0] CHAR_PERIOD = 8'h2e;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;

  localparam logic [CNT_W-1:0] LEN_FWD  = CNT_W'(8);
  localparam logic [CNT_W-1:0] LEN_BWD  = CNT_W'(10);
  localparam logic [CNT_W-1:0] LEN_TURN = CNT_W'(9);

  typedef enum logic [2:0] {
    ST_BYTE      = 3'd0,
    ST_ACCEPT    = 3'd1,
    ST_MALFORMED = 3'd2,
    ST_OVERFLOW  = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    DIR_FWD   = 2'd0,
    DIR_BWD   = 2'd1,
    DIR_RIGHT = 2'd2,
    DIR_LEFT  = 2'd3
  } dir_t;

  typedef logic [BUF_DEPTH-1:0][7:0] char_buf_t;
  typedef logic [CNT_W-1:0]          cnt_t;
  typedef logic [DUTY_W-1:0]         duty_t;

  typedef struct packed {
    logic append;
    logic wipe;
  } buf_ctl_t;

  typedef struct packed {
    status_t status;
    dir_t    direction;
    duty_t   right_duty;
    duty_t   left_duty;
  } result_t;

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  function automatic duty_t three_digits(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] c);
    logic [3:0] da;
    logic [3:0] db;
    logic [3:0] dc;
    da = 4'(a - CHAR_ZERO);
    db = 4'(b - CHAR_ZERO);
    dc = 4'(c - CHAR_ZERO);
    three_digits = DUTY_W'(DUTY_W'(da) * DUTY_W'(100) + DUTY_W'(db) * DUTY_W'(10)
                           + DUTY_W'(dc));
  endfunction

endpackage

`default_nettype wire

/* rtl/mcp_if.sv */
// stream interfaces of the motor command parser: received byte and parse result
// depends on mcp_pkg
`default_nettype none

interface mcp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mcp_result_if;
  logic                 valid;
  logic                 ready;
  mcp_pkg::status_t     status;
  mcp_pkg::dir_t        direction;
  mcp_pkg::duty_t       right_duty;
  mcp_pkg::duty_t       left_duty;

  modport source (output valid, output status, output direction, output right_duty,
                  output left_duty, input ready);
  modport sink   (input valid, input status, input direction, input right_duty,
                  input left_duty, output ready);
endinterface

`default_nettype wire

/* rtl/mcp_matcher.sv */
// command matcher: classifies one byte against the collected buffer and
// checks the four command shapes on a period; depends on mcp_pkg
`default_nettype none

module mcp_matcher (
  input  wire logic [7:0]         rx_byte,
  input  wire mcp_pkg::char_buf_t char_buf,
  input  wire mcp_pkg::cnt_t      char_count,
  output mcp_pkg::result_t        result,
  output mcp_pkg::buf_ctl_t       ctl
);

  logic is_collected;
  logic is_period;
  logic fit_fwd;
  logic fit_bwd;
  logic fit_right;
  logic fit_left;
  logic [7:0] r0, r1, r2, l0, l1, l2;

  assign is_collected = (rx_byte == mcp_pkg::CHAR_R) || (rx_byte == mcp_pkg::CHAR_L) ||
                        (rx_byte == mcp_pkg::CHAR_MINUS) || mcp_pkg::is_digit(rx_byte);
  assign is_period    = (rx_byte == mcp_pkg::CHAR_PERIOD);

  // RdddLddd
  assign fit_fwd = (char_count == mcp_pkg::LEN_FWD) && (char_buf[0] == mcp_pkg::CHAR_R) &&
                   mcp_pkg::is_digit(char_buf[1]) && mcp_pkg::is_digit(char_buf[2]) &&
                   mcp_pkg::is_digit(char_buf[3]) && (char_buf[4] == mcp_pkg::CHAR_L) &&
                   mcp_pkg::is_digit(char_buf[5]) && mcp_pkg::is_digit(char_buf[6]) &&
                   mcp_pkg::is_digit(char_buf[7]);
  // R-dddL-ddd
  assign fit_bwd = (char_count == mcp_pkg::LEN_BWD) && (char_buf[0] == mcp_pkg::CHAR_R) &&
                   (char_buf[1] == mcp_pkg::CHAR_MINUS) && mcp_pkg::is_digit(char_buf[2]) &&
                   mcp_pkg::is_digit(char_buf[3]) && mcp_pkg::is_digit(char_buf[4]) &&
                   (char_buf[5] == mcp_pkg::CHAR_L) && (char_buf[6] == mcp_pkg::CHAR_MINUS) &&
                   mcp_pkg::is_digit(char_buf[7]) && mcp_pkg::is_digit(char_buf[8]) &&
                   mcp_pkg::is_digit(char_buf[9]);
  // R-dddLddd
  assign fit_right = (char_count == mcp_pkg::LEN_TURN) && (char_buf[0] == mcp_pkg::CHAR_R) &&
                     (char_buf[1] == mcp_pkg::CHAR_MINUS) && mcp_pkg::is_digit(char_buf[2]) &&
                     mcp_pkg::is_digit(char_buf[3]) && mcp_pkg::is_digit(char_buf[4]) &&
                     (char_buf[5] == mcp_pkg::CHAR_L) && mcp_pkg::is_digit(char_buf[6]) &&
                     mcp_pkg::is_digit(char_buf[7]) && mcp_pkg::is_digit(char_buf[8]);
  // RdddL-ddd
  assign fit_left = (char_count == mcp_pkg::LEN_TURN) && (char_buf[0] == mcp_pkg::CHAR_R) &&
                    mcp_pkg::is_digit(char_buf[1]) && mcp_pkg::is_digit(char_buf[2]) &&
                    mcp_pkg::is_digit(char_buf[3]) && (char_buf[4] == mcp_pkg::CHAR_L) &&
                    (char_buf[5] == mcp_pkg::CHAR_MINUS) && mcp_pkg::is_digit(char_buf[6]) &&
                    mcp_pkg::is_digit(char_buf[7]) && mcp_pkg::is_digit(char_buf[8]);

  // digit positions: right at 1 unless signed, left after the L and optional minus
  always_comb begin
    if (fit_bwd || fit_right) begin
      r0 = char_buf[2];
      r1 = char_buf[3];
      r2 = char_buf[4];
    end else begin
      r0 = char_buf[1];
      r1 = char_buf[2];
      r2 = char_buf[3];
    end
    if (fit_fwd) begin
      l0 = char_buf[5];
      l1 = char_buf[6];
      l2 = char_buf[7];
    end else if (fit_bwd) begin
      l0 = char_buf[7];
      l1 = char_buf[8];
      l2 = char_buf[9];
    end else begin
      l0 = char_buf[6];
      l1 = char_buf[7];
      l2 = char_buf[8];
    end
  end

  always_comb begin
    result.status     = mcp_pkg::ST_BYTE;
    result.direction  = mcp_pkg::DIR_FWD;
    result.right_duty = '0;
    result.left_duty  = '0;
    ctl.append        = 1'b0;
    ctl.wipe          = 1'b0;
    if (is_collected) begin
      if (char_count >= mcp_pkg::CNT_W'(mcp_pkg::BUF_DEPTH)) begin
        result.status = mcp_pkg::ST_OVERFLOW;
        ctl.wipe      = 1'b1;
      end else begin
        ctl.append = 1'b1;
      end
    end else if (is_period) begin
      if (char_count == '0) begin
        result.status = mcp_pkg::ST_EMPTY;
      end else begin
        ctl.wipe = 1'b1;
        if (fit_fwd || fit_bwd || fit_right || fit_left) begin
          result.status     = mcp_pkg::ST_ACCEPT;
          result.right_duty = mcp_pkg::three_digits(r0, r1, r2);
          result.left_duty  = mcp_pkg::three_digits(l0, l1, l2);
          if (fit_fwd) begin
            result.direction = mcp_pkg::DIR_FWD;
          end else if (fit_bwd) begin
            result.direction = mcp_pkg::DIR_BWD;
          end else if (fit_right) begin
            result.direction = mcp_pkg::DIR_RIGHT;
          end else begin
            result.direction = mcp_pkg::DIR_LEFT;
          end
        end else begin
          result.status = mcp_pkg::ST_MALFORMED;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/motor_command_parser.sv */
// motor command parser top level: input register, character buffer and result register
// depends on mcp_pkg, mcp_if and mcp_matcher
//
// usage:
//   rx carries one received ASCII byte per beat; res returns exactly one result
//   beat per input beat, in order (status, direction, right_duty, left_duty).
//   R, L, minus and digits are collected into a ten-character buffer; a period
//   ends a command and yields accepted, malformed or empty status; an eleventh
//   collected byte clears the buffer and yields overflow. direction and duties
//   are zero unless the status is accepted.
// timing:
//   an input beat is captured in the input register, matched against the buffer
//   and placed in the result register when it advances.
//   one beat per cycle is taken in and given out while res takes each result; the
//   buffer is updated together with the result register, so it holds no beat back.
// reset:
//   rst clears the character count and both valid flags; buffer contents need
//   no clearing since only counted characters are ever compared.
// stall:
//   while res is not taken the result holds and the input register keeps one
//   more beat; rx.ready then drops until res moves again.
`default_nettype none

module motor_command_parser (
  input wire logic           clk,
  input wire logic           rst,
  mcp_byte_if.sink           rx,
  mcp_result_if.source       res
);

  logic               in_valid;
  logic [7:0]         in_byte;
  logic               advance;
  mcp_pkg::char_buf_t char_buf;
  mcp_pkg::cnt_t      char_count;
  mcp_pkg::result_t   match;
  mcp_pkg::buf_ctl_t  ctl;
  logic               out_valid;
  mcp_pkg::result_t   out_result;

  assign advance  = in_valid && (!out_valid || res.ready);
  assign rx.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.ready) begin
      in_valid <= rx.valid;
    end
    if (rx.ready && rx.valid) begin
      in_byte <= rx.rx_byte;
    end
  end

  mcp_matcher u_matcher (
    .rx_byte    (in_byte),
    .char_buf   (char_buf),
    .char_count (char_count),
    .result     (match),
    .ctl        (ctl)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      char_count <= '0;
    end else if (advance) begin
      if (ctl.wipe) begin
        char_count <= '0;
      end else if (ctl.append) begin
        char_count <= char_count + mcp_pkg::cnt_t'(1);
      end
    end
    if (advance && ctl.append) begin
      char_buf[char_count] <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      out_result <= match;
    end
  end

  assign res.valid      = out_valid;
  assign res.status     = out_result.status;
  assign res.direction  = out_result.direction;
  assign res.right_duty = out_result.right_duty;
  assign res.left_duty  = out_result.left_duty;

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    char_count <= mcp_pkg::CNT_W'(mcp_pkg::BUF_DEPTH))
    else $error("character count beyond buffer depth");

  a_clear_after_end: assert property (@(posedge clk) disable iff (rst)
    advance && (match.status == mcp_pkg::ST_OVERFLOW || match.status == mcp_pkg::ST_ACCEPT ||
                match.status == mcp_pkg::ST_MALFORMED) |=> char_count == '0)
    else $error("buffer not cleared after command end or overflow");

  a_fields_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_result.status != mcp_pkg::ST_ACCEPT |->
      out_result.direction == mcp_pkg::DIR_FWD && out_result.right_duty == '0 &&
      out_result.left_duty == '0)
    else $error("command fields set without accepted status");

  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_result.right_duty <= mcp_pkg::DUTY_W'(999) &&
                  out_result.left_duty <= mcp_pkg::DUTY_W'(999))
    else $error("duty value above three digits");

  a_empty_keeps_count: assert property (@(posedge clk) disable iff (rst)
    advance && match.status == mcp_pkg::ST_EMPTY |=> char_count == '0)
    else $error("empty terminator changed the count");

endmodule

`default_nettype wire
